// ===== hdl/ccs_pkg.sv =====
// Package for the connected component sizes unit.
// Request codes, walk state encoding and the stream payload types.
// No dependencies.
`default_nettype none
package ccs_pkg;
  localparam int FIELD_W = 7;

  typedef enum logic [1:0] {
    REQ_ADD   = 2'd0,
    REQ_RUN   = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SEED  = 7'b0000010,
    ST_POP   = 7'b0000100,
    ST_SCAN  = 7'b0001000,
    ST_EMIT  = 7'b0010000,
    ST_NEXT  = 7'b0100000,
    ST_WAIT  = 7'b1000000
  } state_t;

  typedef struct packed {
    logic [FIELD_W-1:0] seed_vertex;
    logic [FIELD_W-1:0] component_size;
    logic               last_component;
  } result_t;
endpackage
`default_nettype wire

// ===== hdl/ccs_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module ccs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hdl/connected_component_sizes_unit.sv =====
// Top level of the connected component sizes unit.
// Uses ccs_pkg and ccs_ram (edge store and walk stack).
//
// Usage: in_ beats carry a request. Add-edge beats (one per cycle while idle) append
// an in-range edge to the edge store while it has room; clear beats empty it; run
// beats start a depth-first component search that emits one out_ beat per component
// (seed vertex and size, tlast on the final one).
// Each popped vertex scans every stored edge, one edge per cycle, through the
// registered read port of the edge store.
// in_tready is low during a run. The result sits in an output register; when
// the receiver stalls, the walk holds at the next result until the waiting one
// is taken.
// Reset empties the edge store, clears the visited map and sets vertex_count
// to 64. The visited map is flip-flops cleared at the start of each run. Configuration
// (vertex_count at address 0) is written over the APB-style port; the user must write
// it only while idle, which the block does not enforce. Reads return the register.
`default_nettype none
module connected_component_sizes_unit #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [15:0] in_tdata,   // edge_from[6:0], edge_to[13:7], zeros
  input  wire logic [1:0]  in_tuser,   // req_type[1:0]
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [15:0] out_tdata,  // seed_vertex[6:0], component_size[13:7], zeros
  output      logic        out_tlast,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [1:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output      logic [31:0] cfg_prdata,
  output      logic        cfg_pready
);
  import ccs_pkg::*;

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int TW = $clog2(MAX_EDGES + 1);
  localparam int CW = $clog2(MAX_VERTICES + 1);

  logic [6:0]    vcount_r;
  logic [TW-1:0] etotal_r;
  state_t        state_r;
  logic [MAX_VERTICES-1:0] vis_r;
  logic [VW-1:0] seed_r;
  logic [VW-1:0] node_r;
  logic [CW-1:0] sp_r;
  logic [CW-1:0] size_r;
  logic [TW-1:0] eidx_r;
  logic          rvalid_r;
  logic          ovalid_r;
  result_t       res_r;

  // effective vertex count clipped to 1..MAX_VERTICES
  logic [CW:0] nlive;
  always_comb begin
    if (vcount_r == '0) nlive = (CW+1)'(1);
    else if (32'(vcount_r) > MAX_VERTICES) nlive = (CW+1)'(MAX_VERTICES);
    else nlive = (CW+1)'(vcount_r);
  end

  // edge store
  logic [2*VW-1:0] e_rdata;
  logic            e_we;
  logic [6:0]      fr, to;
  assign fr = in_tdata[6:0];
  assign to = in_tdata[13:7];
  logic edge_ok;
  assign edge_ok = fr != 7'd0 && to != 7'd0 && (CW+1)'(fr) <= nlive && (CW+1)'(to) <= nlive
                 && etotal_r < TW'(MAX_EDGES);
  logic in_acc;
  assign in_acc = in_tvalid && in_tready;
  assign e_we = in_acc && in_tuser == REQ_ADD && edge_ok;
  logic [VW-1:0] fr0, to0;
  assign fr0 = VW'(fr - 7'd1);
  assign to0 = VW'(to - 7'd1);

  ccs_ram #(.WIDTH(2*VW), .DEPTH(MAX_EDGES)) u_edges (
    .clk, .we(e_we), .waddr(etotal_r[EW-1:0]), .wdata({to0, fr0}),
    .raddr(eidx_r[EW-1:0]), .rdata(e_rdata)
  );

  // walk stack
  logic          s_we;
  logic [VW-1:0] s_wdata;
  logic [VW-1:0] s_rdata;
  logic [VW-1:0] s_waddr;
  ccs_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_stack (
    .clk, .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(VW'(sp_r - CW'(1))), .rdata(s_rdata)
  );

  // scan decode of the edge read in the previous cycle
  logic [VW-1:0] ea, eb;
  assign ea = e_rdata[VW-1:0];
  assign eb = e_rdata[2*VW-1:VW];
  logic in_rng, push;
  logic [VW-1:0] pushv;
  always_comb begin
    in_rng = (CW+1)'(ea) < nlive && (CW+1)'(eb) < nlive;
    push = 1'b0;
    pushv = ea;
    if (in_rng && ea == node_r && !vis_r[eb]) begin
      push = 1'b1;
      pushv = eb;
    end else if (in_rng && eb == node_r && !vis_r[ea]) begin
      push = 1'b1;
      pushv = ea;
    end
  end

  assign s_we    = (state_r == ST_SEED) || (state_r == ST_SCAN && rvalid_r && push);
  assign s_wdata = (state_r == ST_SEED) ? seed_r : pushv;
  assign s_waddr = sp_r[VW-1:0];

  // lowest unvisited vertex below the live count (next seed)
  logic          found;
  logic [VW-1:0] nxt_seed;
  always_comb begin
    found = 1'b0;
    nxt_seed = seed_r;
    for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
      if (!vis_r[i] && (CW+1)'(i) < nlive) begin
        found = 1'b1;
        nxt_seed = VW'(i);
      end
    end
  end

  assign in_tready = state_r == ST_IDLE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      vcount_r <= 7'd64;
      etotal_r <= '0;
      vis_r    <= '0;
      sp_r     <= '0;
      ovalid_r <= 1'b0;
      rvalid_r <= 1'b0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 2'd0)
        vcount_r <= cfg_pwdata[6:0];
      if (ovalid_r && out_tready && state_r != ST_EMIT) ovalid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            case (in_tuser)
              REQ_ADD:   if (edge_ok) etotal_r <= etotal_r + TW'(1);
              REQ_CLEAR: etotal_r <= '0;
              REQ_RUN: begin
                vis_r   <= '0;
                seed_r  <= '0;
                state_r <= ST_SEED;
              end
              default: ;
            endcase
          end
        end
        ST_SEED: begin
          vis_r[seed_r] <= 1'b1;
          sp_r    <= CW'(1);
          size_r  <= CW'(1);
          state_r <= ST_POP;
        end
        ST_POP: begin
          if (sp_r == '0) begin
            state_r <= ST_EMIT;
          end else begin
            state_r <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          node_r  <= s_rdata;
          sp_r    <= sp_r - CW'(1);
          eidx_r  <= '0;
          state_r <= ST_SCAN;
        end
        ST_SCAN: begin
          if (rvalid_r && push) begin
            vis_r[pushv] <= 1'b1;
            sp_r   <= sp_r + CW'(1);
            size_r <= size_r + CW'(1);
          end
          if (eidx_r < etotal_r) begin
            eidx_r   <= eidx_r + TW'(1);
            rvalid_r <= 1'b1;
          end else begin
            rvalid_r <= 1'b0;
            if (!rvalid_r) state_r <= ST_POP;
          end
        end
        ST_EMIT: begin
          if (!ovalid_r || out_tready) begin
            ovalid_r <= 1'b1;
            res_r.seed_vertex    <= 7'(seed_r) + 7'd1;
            res_r.component_size <= 7'(size_r);
            res_r.last_component <= !found;
            state_r <= ST_NEXT;
          end
        end
        ST_NEXT: begin
          if (found) begin
            seed_r  <= nxt_seed;
            state_r <= ST_SEED;
          end else begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {2'b00, res_r.component_size, res_r.seed_vertex};
  assign out_tlast  = res_r.last_component;
  assign cfg_prdata = {25'd0, vcount_r};
  assign cfg_pready = 1'b1;

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> state_r == ST_IDLE) else $error("ready outside idle");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped");
  a_etotal: assert property (@(posedge clk) disable iff (!rst_n)
    etotal_r <= TW'(MAX_EDGES)) else $error("edge total overflow");
  a_seed_vis: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_POP |-> vis_r[seed_r]) else $error("seed not visited");
endmodule
`default_nettype wire

// ===== bench/connected_component_sizes_unit_test.sv =====
// Testbench for connected_component_sizes_unit: drives edge, run, clear and
// unused-code requests and vertex_count writes, and checks every component
// beat against a scoreboard model. Depends on ccs_pkg and the unit's RTL.
`timescale 1ns / 100ps

class component_board;
  bit [5:0] edge_a [256];
  bit [5:0] edge_b [256];
  int unsigned edge_total;
  int unsigned vertex_count;
  bit [14:0] pending [$];
  int errors;

  function void reset_state();
    edge_total = 0;
    vertex_count = 64;
    pending.delete();
    errors = 0;
  endfunction

  function int unsigned live_count();
    if (vertex_count == 0) return 1;
    if (vertex_count > 64) return 64;
    return vertex_count;
  endfunction

  function void note_request(ccs_pkg::req_t req, bit [6:0] from, bit [6:0] to);
    int unsigned n;
    int unsigned seed;
    int unsigned size;
    int unsigned node;
    bit seen [64];
    int unsigned stack [$];
    n = live_count();
    case (req)
      ccs_pkg::REQ_ADD: begin
        if (from >= 1 && from <= n && to >= 1 && to <= n && edge_total < 256) begin
          edge_a[edge_total] = 6'(from - 7'd1);
          edge_b[edge_total] = 6'(to - 7'd1);
          edge_total++;
        end
      end
      ccs_pkg::REQ_CLEAR: edge_total = 0;
      ccs_pkg::REQ_RUN: begin
        seed = 0;
        while (seed < n) begin
          size = 1;
          seen[seed] = 1;
          stack.push_back(seed);
          while (stack.size() > 0) begin
            node = stack.pop_back();
            for (int i = 0; i < edge_total; i++) begin
              if (edge_a[i] >= n || edge_b[i] >= n) continue;
              if (edge_a[i] == node && !seen[edge_b[i]]) begin
                seen[edge_b[i]] = 1; stack.push_back(edge_b[i]); size++;
              end else if (edge_b[i] == node && !seen[edge_a[i]]) begin
                seen[edge_a[i]] = 1; stack.push_back(edge_a[i]); size++;
              end
            end
          end
          pending.push_back({1'b0, 7'(size), 7'(seed + 1)});
          while (seed < n && seen[seed]) seed++;
        end
        pending[pending.size()-1][14] = 1'b1;
      end
      default: ;
    endcase
  endfunction

  function void check_beat(bit [6:0] seed, bit [6:0] size, bit last);
    bit [14:0] exp;
    if (pending.size() == 0) begin
      $display("%0t: unexpected beat seed %0d size %0d last %0b", $time, seed, size, last);
      errors++;
      return;
    end
    exp = pending.pop_front();
    if (exp[6:0] != seed) begin
      $display("%0t: seed expected %0d actual %0d", $time, exp[6:0], seed); errors++;
    end
    if (exp[13:7] != size) begin
      $display("%0t: size expected %0d actual %0d", $time, exp[13:7], size); errors++;
    end
    if (exp[14] != last) begin
      $display("%0t: last expected %0b actual %0b", $time, exp[14], last); errors++;
    end
  endfunction
endclass

module connected_component_sizes_unit_test;
  import ccs_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [15:0] in_tdata = '0;   // edge_from[6:0], edge_to[13:7], zeros
  logic [1:0] in_tuser = '0;    // req_type[1:0]
  logic out_tvalid;
  logic out_tready = 0;
  logic [15:0] out_tdata;       // seed_vertex[6:0], component_size[13:7], zeros
  logic out_tlast;
  logic cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;
  localparam logic [1:0] ADDR_VERTEX_COUNT = 2'd0;

  component_board board;

  connected_component_sizes_unit DUT (.*);

  always #6 clk = ~clk;

  task automatic write_vertex_count(input int unsigned value);
    @(negedge clk);
    cfg_psel <= 1; cfg_pwrite <= 1; cfg_paddr <= ADDR_VERTEX_COUNT;
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    board.vertex_count = value & 7'h7f;
    @(negedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
  endtask

  // called at a falling edge; leaves the beat on the bus until the next call
  task automatic send_request(input req_t req, input bit [6:0] from, input bit [6:0] to);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1; in_tuser <= req; in_tdata <= {2'b0, to, from};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_request(req, from, to);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic random_phase(input int unsigned n_verts, input int unsigned count);
    bit [6:0] f, t;
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        if ($urandom_range(0, 9) == 0) begin
          f = 7'($urandom); t = 7'($urandom);
        end else begin
          f = 7'($urandom_range(1, n_verts)); t = 7'($urandom_range(1, n_verts));
        end
        send_request(REQ_ADD, f, t);
      end else if (pick < 92) send_request(REQ_RUN, 7'($urandom), 7'($urandom));
      else if (pick < 97) send_request(REQ_CLEAR, 7'($urandom), 7'($urandom));
      else send_request(REQ_NONE, 7'($urandom), 7'($urandom));
    end
    send_request(REQ_RUN, 7'd0, 7'd0);
    drain();
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      board.check_beat(out_tdata[6:0], out_tdata[13:7], out_tlast);
  end

  initial begin
    int wait_n;
    forever begin
      wait_n = $urandom_range(0, 13);
      if (wait_n > 0) begin
        out_tready <= 0;
        repeat (wait_n) @(negedge clk);
      end
      out_tready <= 1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    board = new();
    board.reset_state();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    // directed: extremes, self loop, out-of-range, unused code, clear
    send_request(REQ_RUN, 7'd0, 7'd0);
    send_request(REQ_ADD, 7'd1, 7'd64);
    send_request(REQ_ADD, 7'd64, 7'd64);
    send_request(REQ_ADD, 7'd0, 7'd5);
    send_request(REQ_ADD, 7'h7f, 7'h7f);
    send_request(REQ_ADD, 7'd2, 7'd3);
    send_request(REQ_ADD, 7'd3, 7'd1);
    send_request(REQ_NONE, 7'h55, 7'h2a);
    send_request(REQ_RUN, 7'h7f, 7'h7f);
    drain();
    write_vertex_count(3);
    send_request(REQ_RUN, 7'd0, 7'd0);
    send_request(REQ_CLEAR, 7'd0, 7'd0);
    send_request(REQ_RUN, 7'd0, 7'd0);
    drain();
    write_vertex_count(0);
    send_request(REQ_ADD, 7'd1, 7'd1);
    send_request(REQ_RUN, 7'd0, 7'd0);
    drain();
    write_vertex_count(127);
    send_request(REQ_CLEAR, 7'd0, 7'd0);
    send_request(REQ_RUN, 7'd0, 7'd0);
    drain();
    write_vertex_count(1);
    send_request(REQ_ADD, 7'd1, 7'd1);
    send_request(REQ_RUN, 7'd0, 7'd0);
    drain();
    // store-full case: fill past capacity with small graph
    write_vertex_count(4);
    send_request(REQ_CLEAR, 7'd0, 7'd0);
    for (int i = 0; i < 260; i++)
      send_request(REQ_ADD, 7'((i % 4) + 1), 7'(((i * 3) % 4) + 1));
    send_request(REQ_RUN, 7'd0, 7'd0);
    drain();
    write_vertex_count(10);
    send_request(REQ_CLEAR, 7'd0, 7'd0);
    random_phase(10, 25);
    write_vertex_count(64);
    send_request(REQ_CLEAR, 7'd0, 7'd0);
    random_phase(64, 25);
    write_vertex_count(20);
    send_request(REQ_CLEAR, 7'd0, 7'd0);
    random_phase(20, 30);
    write_vertex_count(2);
    random_phase(2, 15);
    drain();
    if (board.errors == 0 && board.pending.size() == 0)
      $display("connected_component_sizes_unit_test passed");
    else
      $display("connected_component_sizes_unit_test failed");
    $finish;
  end

  initial begin
    #60000000;
    $display("connected_component_sizes_unit_test failed");
    $finish;
  end
endmodule
